// File: src/beam_object_height_core_assert.svh
// Assertion macros used by the back end of the beam object height RTL
`ifndef BEAM_OBJECT_HEIGHT_CORE_ASSERT_SVH
`define BEAM_OBJECT_HEIGHT_CORE_ASSERT_SVH

// condition checked at every clock edge outside reset
`define BOH_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// condition in one cycle implies another in the next cycle
`define BOH_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: src/boh_pkg.sv
// Shared types, widths and constants of the beam object height block
package boh_pkg;

    localparam int IDX_W      = 4;
    localparam int RANGE_W    = 16;
    localparam int EXP_W      = 18;
    localparam int ERR_W      = 19;
    localparam int CENTER_W   = 14;
    localparam int HEIGHT_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int DEF_NUM_BEAMS = 16;
    localparam int DEF_BEAM_STEP = 180;

    localparam int ANGLE_W = 17;
    localparam int CMAG_W  = 13;
    localparam int RAD_W   = 19;
    localparam int X_W     = 31;
    localparam int X2_W    = 32;
    localparam int T_W     = 31;
    localparam int Q_FRAC  = 30;
    localparam int COS_W   = 16;
    localparam int DIVD_W  = 31;
    localparam int QUO_W   = 18;
    localparam int NUM_TERMS = 5;

    localparam logic [ANGLE_W-1:0] RIGHT_ANGLE = 17'd5760;
    // pi / 11520 in Q30: radians per 1/64 degree
    localparam logic [RAD_W-1:0]   RAD_Q30     = 19'd292818;
    localparam logic [T_W-1:0]     ONE_Q30     = 31'h4000_0000;
    localparam logic [EXP_W-1:0]   EXP_MAX     = '1;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_ANGLE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_HEIGHT = 1'd1;

    // Horner divisors of the cosine series, highest-order term first
    function automatic int series_div(input int term);
        int d;
        case (term)
            0:       d = 90;
            1:       d = 56;
            2:       d = 30;
            3:       d = 12;
            default: d = 2;
        endcase
        return d;
    endfunction

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [RANGE_W-1:0] meas;
        logic               oor;
    } ctx_t;

    typedef struct packed {
        ctx_t            ctx;
        logic [X2_W-1:0] x2;
        logic [T_W-1:0]  t;
    } cos_pl_t;

    typedef struct packed {
        ctx_t              ctx;
        logic [COS_W-1:0]  cosv;
        logic [DIVD_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
        logic              sat;
    } div_pl_t;

endpackage

// File: src/boh_ifs.sv
// Stream interfaces for detections and results
interface boh_det_if;
    logic                         valid;
    logic                         ready;
    logic [boh_pkg::IDX_W-1:0]    beam_index;
    logic [boh_pkg::RANGE_W-1:0]  measured_range;

    modport source (output valid, beam_index, measured_range, input ready);
    modport sink   (input valid, beam_index, measured_range, output ready);
endinterface

interface boh_res_if;
    logic                        valid;
    logic                        ready;
    logic [boh_pkg::IDX_W-1:0]   beam_echo;
    logic [boh_pkg::EXP_W-1:0]   expected_range;
    logic signed [boh_pkg::ERR_W-1:0] range_error;
    logic signed [boh_pkg::ERR_W-1:0] object_height;
    logic                        angle_out_of_range;

    modport source (output valid, beam_echo, expected_range, range_error, object_height,
                    angle_out_of_range, input ready);
    modport sink   (input valid, beam_echo, expected_range, range_error, object_height,
                    angle_out_of_range, output ready);
endinterface

// File: src/boh_front.sv
// Front end: beam angle, magnitude, radians and squared radians
module boh_front #(
    parameter int NUM_BEAMS = boh_pkg::DEF_NUM_BEAMS,
    parameter int BEAM_STEP = boh_pkg::DEF_BEAM_STEP
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [boh_pkg::IDX_W-1:0]          beam_index,
    input  logic [boh_pkg::RANGE_W-1:0]        measured_range,
    input  logic signed [boh_pkg::CENTER_W-1:0] center_angle,
    output logic                               out_valid,
    input  logic                               out_ready,
    output boh_pkg::cos_pl_t                   out_data
);
    import boh_pkg::*;

    localparam int HALF = NUM_BEAMS / 2;

    logic signed [ANGLE_W-1:0] beam_off;
    logic signed [ANGLE_W-1:0] angle;
    logic [ANGLE_W-1:0]        angle_abs;
    logic                      oor;
    logic [CMAG_W-1:0]         cmag_next;
    ctx_t                      ctx_next;
    logic [CMAG_W+RAD_W-1:0]   x_prod;
    logic [2*X_W-1:0]          x_sq;

    logic [2:0]        v_reg;
    logic              rdy0, rdy1, rdy2;
    ctx_t              ctx0_reg, ctx1_reg, ctx2_reg;
    logic [CMAG_W-1:0] cmag_reg;
    logic [X_W-1:0]    x_reg;
    logic [X2_W-1:0]   x2_reg;

    assign beam_off  = $signed(ANGLE_W'(beam_index)) - $signed(ANGLE_W'(HALF));
    assign angle     = beam_off * $signed(ANGLE_W'(BEAM_STEP)) + ANGLE_W'(center_angle);
    assign angle_abs = angle[ANGLE_W-1] ? ANGLE_W'(-angle) : ANGLE_W'(angle);
    assign oor       = angle_abs >= RIGHT_ANGLE;
    // at or beyond a right angle the cosine is unused; zero keeps the products in range
    assign cmag_next = oor ? '0 : angle_abs[CMAG_W-1:0];
    assign ctx_next  = '{idx: beam_index, meas: measured_range, oor: oor};

    assign x_prod = cmag_reg * RAD_Q30;
    assign x_sq   = x_reg * x_reg;

    assign rdy2     = !v_reg[2] || out_ready;
    assign rdy1     = !v_reg[1] || rdy2;
    assign rdy0     = !v_reg[0] || rdy1;
    assign in_ready = rdy0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy0) v_reg[0] <= in_valid;
            if (rdy1) v_reg[1] <= v_reg[0];
            if (rdy2) v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && in_valid)
        begin
            ctx0_reg <= ctx_next;
            cmag_reg <= cmag_next;
        end
        if (rdy1 && v_reg[0])
        begin
            ctx1_reg <= ctx0_reg;
            x_reg    <= x_prod[X_W-1:0];
        end
        if (rdy2 && v_reg[1])
        begin
            ctx2_reg <= ctx1_reg;
            x2_reg   <= x_sq[X2_W+Q_FRAC-1:Q_FRAC];
        end
    end

    assign out_valid = v_reg[2];
    assign out_data  = '{ctx: ctx2_reg, x2: x2_reg, t: ONE_Q30};

endmodule

// File: src/boh_cos_cell.sv
// One Horner term of the cosine series: t = 1 - (x2*t)/DIV, clamped
module boh_cos_cell #(
    parameter int DIV = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  boh_pkg::cos_pl_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output boh_pkg::cos_pl_t out_data
);
    import boh_pkg::*;

    // floor(2^32 / DIV): quotient estimate is low by at most one
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);

    logic [X2_W+T_W-1:0] prod_a;
    logic [63:0]         prod_b;
    logic [33:0]         rem_c;
    logic [31:0]         q_fix;
    logic signed [33:0]  t_diff;
    logic [T_W-1:0]      t_next;

    logic [2:0]      v_reg;
    logic            rdy_a, rdy_b, rdy_c;
    ctx_t            ctx_a_reg, ctx_b_reg, ctx_c_reg;
    logic [X2_W-1:0] x2_a_reg, x2_b_reg, x2_c_reg;
    logic [X2_W-1:0] p_a_reg, p_b_reg;
    logic [31:0]     q0_reg;
    logic [T_W-1:0]  t_reg;

    assign prod_a = in_data.x2 * in_data.t;
    assign prod_b = p_a_reg * RECIP;
    assign rem_c  = 34'(p_b_reg) - 34'(q0_reg) * 34'(DIV);
    assign q_fix  = q0_reg + 32'(rem_c >= 34'(DIV));
    assign t_diff = $signed(34'(ONE_Q30) - 34'(q_fix));
    assign t_next = t_diff[33] ? '0 : t_diff[T_W-1:0];

    assign rdy_c    = !v_reg[2] || out_ready;
    assign rdy_b    = !v_reg[1] || rdy_c;
    assign rdy_a    = !v_reg[0] || rdy_b;
    assign in_ready = rdy_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy_a) v_reg[0] <= in_valid;
            if (rdy_b) v_reg[1] <= v_reg[0];
            if (rdy_c) v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && in_valid)
        begin
            ctx_a_reg <= in_data.ctx;
            x2_a_reg  <= in_data.x2;
            p_a_reg   <= prod_a[X2_W+Q_FRAC-1:Q_FRAC];
        end
        if (rdy_b && v_reg[0])
        begin
            ctx_b_reg <= ctx_a_reg;
            x2_b_reg  <= x2_a_reg;
            p_b_reg   <= p_a_reg;
            q0_reg    <= prod_b[63:32];
        end
        if (rdy_c && v_reg[1])
        begin
            ctx_c_reg <= ctx_b_reg;
            x2_c_reg  <= x2_b_reg;
            t_reg     <= t_next;
        end
    end

    assign out_valid = v_reg[2];
    assign out_data  = '{ctx: ctx_c_reg, x2: x2_c_reg, t: t_reg};

endmodule

// File: src/boh_div_prep.sv
// Cosine rounding to Q1.15, dividend set-up and saturation check
module boh_div_prep (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  boh_pkg::cos_pl_t              in_data,
    input  logic [boh_pkg::HEIGHT_W-1:0]  sensor_height,
    output logic                          out_valid,
    input  logic                          out_ready,
    output boh_pkg::div_pl_t              out_data
);
    import boh_pkg::*;

    logic [31:0]       cos_sum;
    logic [COS_W-1:0]  cosv;
    logic [DIVD_W-1:0] dividend;
    logic              sat;
    logic              v_reg;
    div_pl_t           d_reg;

    assign cos_sum  = 32'(in_data.t) + 32'(1 << 14);
    assign cosv     = cos_sum[30:15];
    assign dividend = DIVD_W'({sensor_height, 15'd0}) + DIVD_W'(cosv[COS_W-1:1]);
    // angle out of range, or quotient would not fit in the result field
    assign sat      = in_data.ctx.oor || (cosv == '0) ||
                      (34'(dividend) >= {cosv, 18'd0});

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            d_reg <= '{ctx: in_data.ctx, cosv: cosv, rem: dividend, quo: '0, sat: sat};
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

// File: src/boh_div_cell.sv
// One restoring division step: decides quotient bit BIT
module boh_div_cell #(
    parameter int BIT = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  boh_pkg::div_pl_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output boh_pkg::div_pl_t out_data
);
    import boh_pkg::*;

    logic [33:0] shifted;
    logic        ge;
    div_pl_t     d_next;
    logic        v_reg;
    div_pl_t     d_reg;

    assign shifted = 34'(in_data.cosv) << BIT;
    assign ge      = 34'(in_data.rem) >= shifted;

    always_comb
    begin
        d_next = in_data;
        if (ge)
            d_next.rem = DIVD_W'(34'(in_data.rem) - shifted);
        d_next.quo[BIT] = ge;
    end

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            d_reg <= d_next;
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

// File: src/boh_back.sv
// Back end: saturation, range error and rounded object height
`include "beam_object_height_core_assert.svh"

module boh_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  boh_pkg::div_pl_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [boh_pkg::IDX_W-1:0]         beam_echo,
    output logic [boh_pkg::EXP_W-1:0]         expected_range,
    output logic signed [boh_pkg::ERR_W-1:0]  range_error,
    output logic signed [boh_pkg::ERR_W-1:0]  object_height,
    output logic                              angle_out_of_range
);
    import boh_pkg::*;

    logic [EXP_W-1:0]        exp_next;
    logic signed [ERR_W-1:0] err_next;
    logic [EXP_W-1:0]        abs_next;
    logic [EXP_W+COS_W-1:0]  m_next;
    logic [EXP_W+COS_W:0]    m_round;
    logic [EXP_W-1:0]        q_mag;
    logic signed [ERR_W-1:0] h_next;

    logic [2:0]              v_reg;
    logic                    rdy1, rdy2, rdy3;
    logic [IDX_W-1:0]        idx1_reg, idx2_reg, idx3_reg;
    logic                    oor1_reg, oor2_reg, oor3_reg;
    logic [EXP_W-1:0]        exp1_reg, exp2_reg, exp3_reg;
    logic signed [ERR_W-1:0] err1_reg, err2_reg, err3_reg;
    logic [EXP_W-1:0]        abs1_reg;
    logic [COS_W-1:0]        cos1_reg;
    logic                    neg1_reg, neg2_reg;
    logic [EXP_W+COS_W-1:0]  m_reg;
    logic signed [ERR_W-1:0] h3_reg;

    assign exp_next = in_data.sat ? EXP_MAX : in_data.quo;
    assign err_next = $signed(ERR_W'(exp_next)) - $signed(ERR_W'(in_data.ctx.meas));
    assign abs_next = err_next[ERR_W-1] ? EXP_W'(-err_next) : EXP_W'(err_next);

    assign m_next  = abs1_reg * cos1_reg;
    assign m_round = (EXP_W+COS_W+1)'(m_reg) + (EXP_W+COS_W+1)'(1 << 14);
    assign q_mag   = m_round[EXP_W+14:15];
    // rounded half away from zero; no height at or beyond a right angle
    assign h_next  = oor2_reg ? '0 :
                     neg2_reg ? ERR_W'(-$signed(ERR_W'(q_mag))) : ERR_W'(q_mag);

    assign rdy3     = !v_reg[2] || out_ready;
    assign rdy2     = !v_reg[1] || rdy3;
    assign rdy1     = !v_reg[0] || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy1) v_reg[0] <= in_valid;
            if (rdy2) v_reg[1] <= v_reg[0];
            if (rdy3) v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            idx1_reg <= in_data.ctx.idx;
            oor1_reg <= in_data.ctx.oor;
            exp1_reg <= exp_next;
            err1_reg <= err_next;
            abs1_reg <= abs_next;
            cos1_reg <= in_data.cosv;
            neg1_reg <= err_next[ERR_W-1];
        end
        if (rdy2 && v_reg[0])
        begin
            idx2_reg <= idx1_reg;
            oor2_reg <= oor1_reg;
            exp2_reg <= exp1_reg;
            err2_reg <= err1_reg;
            neg2_reg <= neg1_reg;
            m_reg    <= m_next;
        end
        if (rdy3 && v_reg[1])
        begin
            idx3_reg <= idx2_reg;
            oor3_reg <= oor2_reg;
            exp3_reg <= exp2_reg;
            err3_reg <= err2_reg;
            h3_reg   <= h_next;
        end
    end

    assign out_valid          = v_reg[2];
    assign beam_echo          = idx3_reg;
    assign expected_range     = exp3_reg;
    assign range_error        = err3_reg;
    assign object_height      = h3_reg;
    assign angle_out_of_range = oor3_reg;

    `BOH_ASSERT_ALWAYS(a_oor_saturates, !v_reg[2] || !oor3_reg || (exp3_reg == EXP_MAX && h3_reg == '0), "out-of-range item not saturated")
    `BOH_ASSERT_ALWAYS(a_height_sign, !v_reg[2] || h3_reg == '0 || h3_reg[ERR_W-1] == err3_reg[ERR_W-1], "height sign differs from range error")
    `BOH_ASSERT_NEXT(a_stage_moves, v_reg[1] && rdy3, v_reg[2], "item lost between product and output")

endmodule

// File: src/beam_object_height_core.sv
// Top level of the beam object height block
//
//  port  | dir | role                           | fields
//  ------+-----+--------------------------------+-----------------------------------------
//  det   | in  | detection item, valid/ready    | beam_index, measured_range
//  res   | out | result item, valid/ready       | beam_echo, expected_range, range_error,
//        |     |                                | object_height, angle_out_of_range
//  cfg_* | in  | register write, no wait        | cfg_index, cfg_wdata
//
// One item per cycle unless the output stalls; 40 register stages from det to res:
// front 3, five series terms of 3 each, set-up 1, 18 division steps, back end 3.
// Most stages lie in the 18 one-bit division cells and the cosine series cells.
// Every stage holds its own valid bit, so bubbles close up under a stall and input
// keeps flowing while a result waits at the output register, until every stage is full.
// Reset clears the pipeline valid bits and both registers.
module beam_object_height_core #(
    parameter int NUM_BEAMS = boh_pkg::DEF_NUM_BEAMS,
    parameter int BEAM_STEP = boh_pkg::DEF_BEAM_STEP
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [boh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [boh_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    boh_det_if.sink                           det,
    boh_res_if.source                         res
);
    import boh_pkg::*;

    logic signed [CENTER_W-1:0] center_angle_reg;
    logic [HEIGHT_W-1:0]        sensor_height_reg;

    cos_pl_t cos_d [0:NUM_TERMS];
    logic    cos_v [0:NUM_TERMS];
    logic    cos_r [0:NUM_TERMS];
    div_pl_t div_d [0:QUO_W];
    logic    div_v [0:QUO_W];
    logic    div_r [0:QUO_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_angle_reg  <= '0;
            sensor_height_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_ANGLE:  center_angle_reg  <= cfg_wdata[CENTER_W-1:0];
                REG_SENSOR_HEIGHT: sensor_height_reg <= cfg_wdata[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    boh_front #(
        .NUM_BEAMS(NUM_BEAMS),
        .BEAM_STEP(BEAM_STEP)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (det.valid),
        .in_ready      (det.ready),
        .beam_index    (det.beam_index),
        .measured_range(det.measured_range),
        .center_angle  (center_angle_reg),
        .out_valid     (cos_v[0]),
        .out_ready     (cos_r[0]),
        .out_data      (cos_d[0])
    );

    for (genvar i = 0; i < NUM_TERMS; i++)
    begin : g_cos
        boh_cos_cell #(
            .DIV(series_div(i))
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (cos_v[i]),
            .in_ready (cos_r[i]),
            .in_data  (cos_d[i]),
            .out_valid(cos_v[i+1]),
            .out_ready(cos_r[i+1]),
            .out_data (cos_d[i+1])
        );
    end

    boh_div_prep u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (cos_v[NUM_TERMS]),
        .in_ready     (cos_r[NUM_TERMS]),
        .in_data      (cos_d[NUM_TERMS]),
        .sensor_height(sensor_height_reg),
        .out_valid    (div_v[0]),
        .out_ready    (div_r[0]),
        .out_data     (div_d[0])
    );

    // most significant quotient bit first
    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        boh_div_cell #(
            .BIT(QUO_W - 1 - j)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (div_v[j]),
            .in_ready (div_r[j]),
            .in_data  (div_d[j]),
            .out_valid(div_v[j+1]),
            .out_ready(div_r[j+1]),
            .out_data (div_d[j+1])
        );
    end

    boh_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (div_v[QUO_W]),
        .in_ready          (div_r[QUO_W]),
        .in_data           (div_d[QUO_W]),
        .out_valid         (res.valid),
        .out_ready         (res.ready),
        .beam_echo         (res.beam_echo),
        .expected_range    (res.expected_range),
        .range_error       (res.range_error),
        .object_height     (res.object_height),
        .angle_out_of_range(res.angle_out_of_range)
    );

endmodule
